[design/prlt_pkg.sv]
// Package for the ping RTT and loss tracker: ring sizing, time constants,
// register indices and the sequencer state type. Used by every module of the block.
package prlt_pkg;

  localparam int RING_DEPTH = 1024;
  localparam int SLOT_W = $clog2(RING_DEPTH);
  localparam int PEND_W = SLOT_W + 1;

  localparam logic [63:0] NS_PER_US = 64'd1000;
  localparam logic [63:0] NS_PER_MS = 64'd1000000;
  localparam logic [63:0] IDLE_WAKE_NS = 64'd100 * NS_PER_MS;

  localparam logic [2:0] REG_TOTAL = 3'd0;
  localparam logic [2:0] REG_INTERVAL = 3'd1;
  localparam logic [2:0] REG_EXPIRY = 3'd2;
  localparam logic [2:0] REG_PERIOD = 3'd3;
  localparam logic [2:0] REG_FIRST = 3'd4;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_PONG   = 10'b0000000010,
    ST_EXPRD  = 10'b0000000100,
    ST_EXPCHK = 10'b0000001000,
    ST_REPORT = 10'b0000010000,
    ST_SEND   = 10'b0000100000,
    ST_WRD    = 10'b0001000000,
    ST_WAKE   = 10'b0010000000,
    ST_WFIN   = 10'b0100000000,
    ST_OUT    = 10'b1000000000
  } state_t;

endpackage

[design/prlt_ring.sv]
// Ring of pending pings: sequence, send time and valid flag per slot.
// Depends on prlt_pkg. Reads are registered; valid bits are flip-flops.
module prlt_ring (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [prlt_pkg::SLOT_W-1:0] rd_addr,
  output logic                      rd_valid,
  output logic [31:0]               rd_seq,
  output logic [63:0]               rd_time,
  input  logic                      wr_en,
  input  logic [prlt_pkg::SLOT_W-1:0] wr_addr,
  input  logic [31:0]               wr_seq,
  input  logic [63:0]               wr_time,
  input  logic                      clr_en,
  input  logic [prlt_pkg::SLOT_W-1:0] clr_addr
);
  import prlt_pkg::*;

  logic [31:0] seq_mem [RING_DEPTH];
  logic [63:0] time_mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      seq_mem[wr_addr] <= wr_seq;
      time_mem[wr_addr] <= wr_time;
    end
    rd_seq <= seq_mem[rd_addr];
    rd_time <= time_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (clr_en) valid[clr_addr] <= 1'b0;
      if (wr_en) valid[wr_addr] <= 1'b1;
      rd_valid <= valid[rd_addr];
    end
  end

endmodule

[design/ping_rtt_loss_tracker.sv]
// Top level of the ping RTT and loss tracker.
// Depends on prlt_pkg and prlt_ring.
//
// The tracker takes one transaction at a time. A pong goes from acceptance
// to a result through a registered read of the ring, a match and update step,
// then the result register. A tick walks the ring from the oldest pending
// ping, each slot examined with a registered read and a compare on the shared
// 64-bit subtract/compare unit, and then runs the report, send and wakeup
// steps before the result register; the length of the expiry walk sets how
// long a tick takes. The result waits in an output register while stalled,
// and input stall stays high until it has gone. Configuration is written
// through a simple write port; the user must write it only while the block is
// idle, and the block itself does not enforce this. Writing the report period
// or first ping time before any ping is sent reloads both due times.
module ping_rtt_loss_tracker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [63:0] now_ns,
  input  logic [31:0] pong_sequence,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        send_valid,
  output logic [31:0] send_sequence,
  output logic        report_valid,
  output logic [63:0] report_rtt_sum_ns,
  output logic [31:0] report_received,
  output logic [31:0] report_losses,
  output logic        run_done,
  output logic        sample_valid,
  output logic [63:0] sample_sent_at_ns,
  output logic [63:0] sample_rtt_ns,
  output logic [63:0] next_wakeup_ns
);
  import prlt_pkg::*;

  state_t state;

  logic [31:0] total_pings;
  logic [63:0] ping_interval_ns, expiry_ns, report_period_ns, first_ping_time_ns;

  logic [31:0] sent_counter, expiry_pointer, loss_counter, sample_counter;
  logic [PEND_W-1:0] pending_counter;
  logic [63:0] rtt_accumulator, ping_due_time, report_due_time;

  logic [63:0] now;
  logic [31:0] pseq;
  logic [63:0] wake;

  // Ring interface
  logic [SLOT_W-1:0] rd_addr, wr_addr, clr_addr;
  logic rd_valid, wr_en, clr_en;
  logic [31:0] rd_seq;
  logic [63:0] rd_time;

  prlt_ring u_ring (
    .clk, .rst, .rd_addr, .rd_valid, .rd_seq, .rd_time,
    .wr_en, .wr_addr, .wr_seq(sent_counter), .wr_time(now),
    .clr_en, .clr_addr
  );

  // Shared subtract/compare unit: a - b, and whether a < b.
  logic [63:0] alu_a, alu_b, alu_diff;
  logic alu_lt;
  assign {alu_lt, alu_diff} = {1'b0, alu_a} - {1'b0, alu_b};

  logic entry_match;
  logic in_acc;
  assign in_acc = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE) || out_valid;

  always_comb begin
    alu_a = now;
    alu_b = 64'd0;
    case (state)
      ST_PONG:   begin alu_a = now; alu_b = rd_time; end
      ST_EXPCHK: begin alu_a = now - rd_time; alu_b = expiry_ns; end
      ST_REPORT: begin alu_a = now; alu_b = report_due_time; end
      ST_SEND:   begin alu_a = now; alu_b = ping_due_time; end
      ST_WAKE:   begin alu_a = rd_time + expiry_ns; alu_b = wake; end
      ST_WFIN:   begin alu_a = now; alu_b = wake; end
      default:   begin alu_a = now; alu_b = 64'd0; end
    endcase
  end

  assign entry_match = rd_valid && (rd_seq == expiry_pointer);

  always_comb begin
    rd_addr = expiry_pointer[SLOT_W-1:0];
    if (state == ST_IDLE) rd_addr = pong_sequence[SLOT_W-1:0];
    else if (state == ST_REPORT) rd_addr = sent_counter[SLOT_W-1:0];
  end

  logic done_cond;
  assign done_cond = (sent_counter >= total_pings) && (pending_counter == '0);

  always_comb begin
    wr_en = 1'b0;
    wr_addr = sent_counter[SLOT_W-1:0];
    clr_en = 1'b0;
    clr_addr = expiry_pointer[SLOT_W-1:0];
    case (state)
      ST_PONG: begin
        clr_addr = pseq[SLOT_W-1:0];
        clr_en = rd_valid && (rd_seq == pseq);
      end
      ST_EXPCHK: clr_en = (expiry_pointer < sent_counter) && entry_match && !alu_lt;
      ST_SEND: wr_en = !done_cond && (sent_counter < total_pings) && !alu_lt && !rd_valid;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      total_pings <= 32'd10;
      ping_interval_ns <= 64'd500000000;
      expiry_ns <= 64'd1000000000;
      report_period_ns <= 64'd1000000000;
      first_ping_time_ns <= 64'd0;
      sent_counter <= '0;
      expiry_pointer <= '0;
      loss_counter <= '0;
      sample_counter <= '0;
      pending_counter <= '0;
      rtt_accumulator <= '0;
      ping_due_time <= 64'd0;
      report_due_time <= 64'd1000000000;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cfg_write) begin
        case (cfg_index)
          REG_TOTAL:    total_pings <= cfg_data[31:0];
          REG_INTERVAL: ping_interval_ns <= cfg_data;
          REG_EXPIRY:   expiry_ns <= cfg_data;
          REG_PERIOD: begin
            report_period_ns <= cfg_data;
            if (sent_counter == '0) begin
              ping_due_time <= first_ping_time_ns;
              report_due_time <= first_ping_time_ns + cfg_data;
            end
          end
          REG_FIRST: begin
            first_ping_time_ns <= cfg_data;
            if (sent_counter == '0) begin
              ping_due_time <= cfg_data;
              report_due_time <= cfg_data + report_period_ns;
            end
          end
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            now <= now_ns;
            pseq <= pong_sequence;
            send_valid <= 1'b0;
            send_sequence <= '0;
            report_valid <= 1'b0;
            report_rtt_sum_ns <= '0;
            report_received <= '0;
            report_losses <= '0;
            run_done <= 1'b0;
            sample_valid <= 1'b0;
            sample_sent_at_ns <= '0;
            sample_rtt_ns <= '0;
            next_wakeup_ns <= '0;
            state <= command ? ST_PONG : ST_EXPRD;
          end
        end
        ST_PONG: begin
          if (rd_valid && (rd_seq == pseq)) begin
            if (pending_counter != '0) pending_counter <= pending_counter - 1'b1;
            rtt_accumulator <= rtt_accumulator + alu_diff;
            if (sample_counter != 32'hFFFFFFFF) sample_counter <= sample_counter + 1'b1;
            sample_valid <= 1'b1;
            sample_sent_at_ns <= rd_time;
            sample_rtt_ns <= alu_diff;
          end
          state <= ST_OUT;
        end
        ST_EXPRD: state <= ST_EXPCHK;  // ring read of the oldest slot
        ST_EXPCHK: begin
          if (expiry_pointer >= sent_counter) begin
            state <= ST_REPORT;
          end else if (!entry_match) begin
            expiry_pointer <= expiry_pointer + 1'b1;
            state <= ST_EXPRD;
          end else if (alu_lt) begin
            state <= ST_REPORT;
          end else begin
            if (pending_counter != '0) pending_counter <= pending_counter - 1'b1;
            loss_counter <= loss_counter + 1'b1;
            expiry_pointer <= expiry_pointer + 1'b1;
            state <= ST_EXPRD;
          end
        end
        ST_REPORT: begin
          // Periodic report; the ring read of the next send slot runs alongside.
          if (!alu_lt) begin
            report_valid <= 1'b1;
            report_rtt_sum_ns <= rtt_accumulator;
            report_received <= sample_counter;
            rtt_accumulator <= '0;
            sample_counter <= '0;
            report_due_time <= now + report_period_ns;
          end
          state <= ST_SEND;
        end
        ST_SEND: begin
          if (done_cond) begin
            if (!report_valid) begin
              report_valid <= 1'b1;
              report_rtt_sum_ns <= rtt_accumulator;
              report_received <= sample_counter;
              rtt_accumulator <= '0;
              sample_counter <= '0;
            end
            run_done <= 1'b1;
          end else if ((sent_counter < total_pings) && !alu_lt) begin
            if (rd_valid) begin
              ping_due_time <= now + NS_PER_MS;
            end else begin
              pending_counter <= pending_counter + 1'b1;
              send_valid <= 1'b1;
              send_sequence <= sent_counter;
              sent_counter <= sent_counter + 1'b1;
              ping_due_time <= now + ping_interval_ns;
            end
          end
          state <= ST_WRD;
        end
        ST_WRD: begin
          // Ring read of the oldest slot for its expiry time; first candidates.
          if ((sent_counter < total_pings) && (ping_due_time < now + IDLE_WAKE_NS))
            wake <= ping_due_time;
          else
            wake <= now + IDLE_WAKE_NS;
          state <= ST_WAKE;
        end
        ST_WAKE: begin
          if ((pending_counter != '0) && entry_match && alu_lt &&
              ((rd_time + expiry_ns) < report_due_time || report_due_time >= wake))
            wake <= rd_time + expiry_ns;
          else if (report_due_time < wake)
            wake <= report_due_time;
          state <= ST_WFIN;
        end
        ST_WFIN: begin
          // The wakeup must lie strictly after the current time.
          next_wakeup_ns <= alu_lt ? wake : now + NS_PER_US;
          if (report_valid) report_losses <= loss_counter;
          state <= ST_OUT;
        end
        ST_OUT: begin
          out_valid <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[verif/tb_ping_rtt_loss_tracker.sv]
// Self-checking testbench for ping_rtt_loss_tracker: directed and random ticks and pongs,
// checked against a behavioural tracker model kept inside this file.
// Depends on prlt_pkg and the ping_rtt_loss_tracker RTL.
`timescale 1ns / 100ps

module tb_ping_rtt_loss_tracker;
  import prlt_pkg::*;

  // Index 5 lies beyond the register list, so writes to it must be ignored.
  localparam logic [2:0] REG_UNUSED = 3'd5;
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_PONG = 1'b1;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        command;
  logic [63:0] now_ns;
  logic [31:0] pong_sequence;
  logic        out_valid;
  logic        out_stall;
  logic        send_valid;
  logic [31:0] send_sequence;
  logic        report_valid;
  logic [63:0] report_rtt_sum_ns;
  logic [31:0] report_received;
  logic [31:0] report_losses;
  logic        run_done;
  logic        sample_valid;
  logic [63:0] sample_sent_at_ns;
  logic [63:0] sample_rtt_ns;
  logic [63:0] next_wakeup_ns;

  ping_rtt_loss_tracker dut (.*);

  // One expected result of the tracker.
  typedef struct {
    logic        send_valid;
    logic [31:0] send_sequence;
    logic        report_valid;
    logic [63:0] report_rtt_sum_ns;
    logic [31:0] report_received;
    logic [31:0] report_losses;
    logic        run_done;
    logic        sample_valid;
    logic [63:0] sample_sent_at_ns;
    logic [63:0] sample_rtt_ns;
    logic [63:0] next_wakeup_ns;
  } tracker_result_t;

  tracker_result_t expected_results[$];

  // Model copy of the configuration registers.
  logic [31:0] m_total;
  logic [63:0] m_interval;
  logic [63:0] m_expiry;
  logic [63:0] m_period;
  logic [63:0] m_first;

  // Model copy of the tracker state.
  logic [31:0] m_slot_seq [RING_DEPTH];
  logic [63:0] m_slot_time [RING_DEPTH];
  logic        m_slot_busy [RING_DEPTH];
  logic [31:0] m_sent;
  logic [31:0] m_pending;
  logic [31:0] m_oldest;
  logic [31:0] m_losses;
  logic [63:0] m_rtt_sum;
  logic [31:0] m_samples;
  logic [63:0] m_ping_due;
  logic [63:0] m_report_due;

  // Monotonic test time, advanced by the tests.
  logic [63:0] wall_ns;

  logic quiet;
  logic long_hold;
  logic failed;
  int   cycles;
  int   n_items;
  int   n_results;
  int   n_sends;
  int   n_reports;
  int   n_samples;
  int   n_done;

  // Clock generation: 8 ns period.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles", cycles);
    $display("Mismatches found");
    $finish;
  end

  // Reset state of the model, mirroring the block's reset values.
  task automatic model_reset();
    m_total = 32'd10;
    m_interval = 64'd500000000;
    m_expiry = 64'd1000000000;
    m_period = 64'd1000000000;
    m_first = 64'd0;
    for (int i = 0; i < RING_DEPTH; i++) begin
      m_slot_seq[i] = '0;
      m_slot_time[i] = '0;
      m_slot_busy[i] = 1'b0;
    end
    m_sent = '0;
    m_pending = '0;
    m_oldest = '0;
    m_losses = '0;
    m_rtt_sum = '0;
    m_samples = '0;
    m_ping_due = m_first;
    m_report_due = m_first + m_period;
  endtask

  // A register write updates the model; the report period and first ping time
  // also reload both due times as long as nothing has been sent.
  task automatic model_register(logic [2:0] idx, logic [63:0] value);
    case (idx)
      REG_TOTAL: begin
        m_total = value[31:0];
      end
      REG_INTERVAL: begin
        m_interval = value;
      end
      REG_EXPIRY: begin
        m_expiry = value;
      end
      REG_PERIOD: begin
        m_period = value;
      end
      REG_FIRST: begin
        m_first = value;
      end
      default: begin
      end
    endcase
    if ((idx == REG_PERIOD || idx == REG_FIRST) && m_sent == 0) begin
      m_ping_due = m_first;
      m_report_due = m_first + m_period;
    end
  endtask

  // Earliest of the idle wakeup, the next ping, the next report and the
  // expiry of the oldest pending ping; never at or before the current time.
  function automatic logic [63:0] wakeup_after(logic [63:0] now);
    logic [63:0] w;
    logic [63:0] lapse;
    logic [SLOT_W-1:0] s;
    w = now + IDLE_WAKE_NS;
    if (m_sent < m_total && m_ping_due < w) w = m_ping_due;
    if (m_report_due < w) w = m_report_due;
    s = m_oldest[SLOT_W-1:0];
    if (m_pending != 0 && m_slot_busy[s] && m_slot_seq[s] == m_oldest) begin
      lapse = m_slot_time[s] + m_expiry;
      if (lapse < w) w = lapse;
    end
    return (w > now) ? w : now + NS_PER_US;
  endfunction

  // Advances the model by one accepted transaction and queues its result.
  task automatic track_transaction(logic cmd, logic [63:0] now, logic [31:0] seq);
    tracker_result_t r;
    logic [SLOT_W-1:0] s;
    logic [63:0] rtt;
    r = '{default: '0};
    if (cmd == CMD_PONG) begin
      s = seq[SLOT_W-1:0];
      if (m_slot_busy[s] && m_slot_seq[s] == seq) begin
        rtt = now - m_slot_time[s];
        m_slot_busy[s] = 1'b0;
        if (m_pending != 0) m_pending--;
        m_rtt_sum += rtt;
        if (m_samples != 32'hFFFF_FFFF) m_samples++;
        r.sample_valid = 1'b1;
        r.sample_sent_at_ns = m_slot_time[s];
        r.sample_rtt_ns = rtt;
      end
    end else begin
      // Expiry walk from the oldest sequence that may still be pending.
      while (m_oldest < m_sent) begin
        s = m_oldest[SLOT_W-1:0];
        if (m_slot_busy[s] && m_slot_seq[s] == m_oldest) begin
          if (now - m_slot_time[s] < m_expiry) break;
          m_slot_busy[s] = 1'b0;
          if (m_pending != 0) m_pending--;
          m_losses++;
        end
        m_oldest++;
      end
      if (now >= m_report_due) begin
        r.report_valid = 1'b1;
        r.report_rtt_sum_ns = m_rtt_sum;
        r.report_received = m_samples;
        m_rtt_sum = '0;
        m_samples = '0;
        m_report_due = now + m_period;
      end
      if (m_sent >= m_total && m_pending == 0) begin
        // A final report merges with a periodic one in the same tick.
        if (!r.report_valid) begin
          r.report_valid = 1'b1;
          r.report_rtt_sum_ns = m_rtt_sum;
          r.report_received = m_samples;
          m_rtt_sum = '0;
          m_samples = '0;
        end
        r.run_done = 1'b1;
      end else if (m_sent < m_total && now >= m_ping_due) begin
        s = m_sent[SLOT_W-1:0];
        if (m_slot_busy[s]) begin
          // Slot still holds an older ping: retry a millisecond later.
          m_ping_due = now + NS_PER_MS;
        end else begin
          m_slot_seq[s] = m_sent;
          m_slot_time[s] = now;
          m_slot_busy[s] = 1'b1;
          m_pending++;
          r.send_valid = 1'b1;
          r.send_sequence = m_sent;
          m_sent++;
          m_ping_due = now + m_interval;
        end
      end
      if (r.report_valid) r.report_losses = m_losses;
      r.next_wakeup_ns = wakeup_after(now);
    end
    expected_results.push_back(r);
  endtask

  // Sends one transaction, with an occasional random gap before it, and
  // updates the model once the block has accepted it.
  task automatic send_item(logic cmd, logic [63:0] now, logic [31:0] seq);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid = 1'b1;
    command = cmd;
    now_ns = now;
    pong_sequence = seq;
    do @(posedge clk); while (in_stall);
    n_items++;
    track_transaction(cmd, now, seq);
  endtask

  // Stops offering transactions and waits until every result has come out.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // Writes one register; only called while the block is idle.
  task automatic write_register(logic [2:0] idx, logic [63:0] value);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_write = 1'b0;
    model_register(idx, value);
  endtask

  task automatic tick_at(logic [63:0] t);
    wall_ns = t;
    send_item(CMD_TICK, t, '0);
  endtask

  task automatic pong_at(logic [63:0] t, logic [31:0] seq);
    wall_ns = t;
    send_item(CMD_PONG, t, seq);
  endtask

  // Receiver stall: random bursts, plus one long hold on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall = 1'b1;
        repeat (400) @(negedge clk);
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 19) - 1) @(negedge clk);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  function automatic void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      failed = 1'b1;
    end
  endfunction

  // Result checker: every accepted result is matched against the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    tracker_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("Result with no transaction outstanding");
        failed = 1'b1;
      end else begin
        e = expected_results.pop_front();
        n_results++;
        if (e.send_valid) n_sends++;
        if (e.report_valid) n_reports++;
        if (e.sample_valid) n_samples++;
        if (e.run_done) n_done++;
        compare_field("send_valid", e.send_valid, send_valid);
        compare_field("send_sequence", e.send_sequence, send_sequence);
        compare_field("report_valid", e.report_valid, report_valid);
        compare_field("report_rtt_sum_ns", e.report_rtt_sum_ns, report_rtt_sum_ns);
        compare_field("report_received", e.report_received, report_received);
        compare_field("report_losses", e.report_losses, report_losses);
        compare_field("run_done", e.run_done, run_done);
        compare_field("sample_valid", e.sample_valid, sample_valid);
        compare_field("sample_sent_at_ns", e.sample_sent_at_ns, sample_sent_at_ns);
        compare_field("sample_rtt_ns", e.sample_rtt_ns, sample_rtt_ns);
        compare_field("next_wakeup_ns", e.next_wakeup_ns, next_wakeup_ns);
      end
    end
  end

  // Due-time reload before the first send, a short run to completion with
  // answered, lost and unmatched pings, a merged final report and the
  // extremes of time and sequence.
  task automatic test_basic_run();
    write_register(REG_FIRST, 64'd1000);
    write_register(REG_PERIOD, 64'd2500);
    write_register(REG_EXPIRY, 64'd3000);
    write_register(REG_INTERVAL, 64'd500);
    write_register(REG_TOTAL, 64'd4);
    write_register(REG_UNUSED, ALL_ONES);
    tick_at(64'd0);
    tick_at(64'd1000);
    pong_at(64'd1200, 32'd0);
    tick_at(64'd1500);
    tick_at(64'd2000);
    tick_at(64'd3500);
    pong_at(64'd3600, 32'd2);
    pong_at(64'd3610, 32'd2);
    pong_at(64'd3620, 32'd99);
    pong_at(64'd3630, 32'hFFFF_FFFF);
    tick_at(64'd5000);
    tick_at(64'd6600);
    tick_at(64'd7000);
    pong_at(64'd7100, 32'd3);
    tick_at(64'd8000);
    send_item(CMD_PONG, ALL_ONES, 32'hFFFF_FFFF);
    send_item(CMD_TICK, ALL_ONES, 32'hFFFF_FFFF);
    drain();
  endtask

  // Extreme register settings: the largest count, interval, expiry and period,
  // then the smallest interval, expiry and period, each with a few transactions.
  task automatic test_extreme_settings();
    write_register(REG_TOTAL, 64'hFFFF_FFFF);
    write_register(REG_INTERVAL, ALL_ONES);
    write_register(REG_EXPIRY, ALL_ONES);
    write_register(REG_PERIOD, ALL_ONES);
    write_register(REG_FIRST, ALL_ONES);
    tick_at(64'd10000);
    tick_at(64'd10001);
    pong_at(64'd10050, m_sent - 1);
    tick_at(64'd20000);
    drain();
    write_register(REG_INTERVAL, 64'd1);
    write_register(REG_EXPIRY, 64'd1);
    write_register(REG_PERIOD, 64'd1);
    write_register(REG_FIRST, 64'd0);
    tick_at(64'd30000);
    tick_at(64'd30001);
    tick_at(64'd30003);
    pong_at(64'd30004, m_sent - 1);
    tick_at(64'd30010);
    drain();
  endtask

  // Fills every ring slot, so the next ping finds its slot busy and retries;
  // a pong frees the slot, then a short expiry walks the whole ring at once.
  task automatic test_full_ring();
    logic [31:0] oldest;
    write_register(REG_EXPIRY, ALL_ONES);
    write_register(REG_PERIOD, 64'd1000000);
    write_register(REG_INTERVAL, 64'd1);
    for (int k = 0; k < RING_DEPTH + 6; k++) tick_at(wall_ns + $urandom_range(1, 40));
    tick_at(wall_ns + NS_PER_MS);
    oldest = m_sent - RING_DEPTH;
    pong_at(wall_ns + 5, oldest);
    tick_at(wall_ns + NS_PER_MS);
    tick_at(wall_ns + 10);
    drain();
    write_register(REG_EXPIRY, 64'd1000);
    tick_at(wall_ns + 5000);
    drain();
    write_register(REG_TOTAL, {32'd0, m_sent});
    tick_at(wall_ns + 100);
    tick_at(wall_ns + 100);
    drain();
  endtask

  // The receiver holds off for a long stretch while ticks keep coming, so
  // the block fills and stalls its input.
  task automatic test_output_hold();
    write_register(REG_TOTAL, 64'hFFFF_FFFF);
    write_register(REG_INTERVAL, 64'd700);
    write_register(REG_EXPIRY, 64'd6000);
    write_register(REG_PERIOD, 64'd3000);
    long_hold = 1'b1;
    for (int k = 0; k < 8; k++) tick_at(wall_ns + 400);
    drain();
  endtask

  // Random traffic: mostly ticks and pongs for recent sequences with time
  // moving forward, and some noise pongs with arbitrary time and sequence.
  task automatic test_random_traffic(int count);
    int pick;
    logic [31:0] back;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        tick_at(wall_ns + $urandom_range(0, 1500));
      end else if (pick < 88) begin
        back = $urandom_range(1, 10);
        pong_at(wall_ns + $urandom_range(0, 300), m_sent - back);
      end else if (pick < 97) begin
        send_item(CMD_PONG, {$urandom, $urandom}, $urandom);
      end else begin
        // Jump far ahead so the upper time bits get exercised too.
        tick_at(wall_ns + ({$urandom, $urandom} >> $urandom_range(4, 40)));
      end
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    command = CMD_TICK;
    now_ns = '0;
    pong_sequence = '0;
    quiet = 1'b0;
    long_hold = 1'b0;
    failed = 1'b0;
    cycles = 0;
    n_items = 0;
    n_results = 0;
    n_sends = 0;
    n_reports = 0;
    n_samples = 0;
    n_done = 0;
    wall_ns = '0;
    model_reset();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_basic_run();
    test_extreme_settings();
    test_full_ring();
    test_output_hold();
    test_random_traffic(250);
    // Second random phase under a different setting.
    write_register(REG_INTERVAL, 64'd300);
    write_register(REG_EXPIRY, 64'd2000);
    write_register(REG_PERIOD, 64'd5000);
    test_random_traffic(150);
    // Last part of the run: no idling on either side.
    quiet = 1'b1;
    test_random_traffic(100);

    $display("Covered %0d transactions and %0d results: %0d sends, %0d reports,",
             n_items, n_results, n_sends, n_reports);
    $display("%0d samples, %0d done flags and %0d losses counted.",
             n_samples, n_done, m_losses);
    if (!failed && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
